// ===== rtl/pts_pkg.sv =====
`timescale 1ns / 1ps

package pts_pkg;

    // Scheduler geometry.
    localparam int NUM_TASKS        = 8;
    localparam int COUNT_W          = 16;
    localparam int SLOT_W           = $clog2(NUM_TASKS);
    localparam int STEP_W           = $clog2(COUNT_W + 1);
    localparam int PERIODS_PER_WORD = 4;
    localparam int CFG_DATA_W       = PERIODS_PER_WORD * COUNT_W;
    localparam int CFG_IDX_W        = 2;
    localparam int KIND_W           = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [SLOT_W-1:0]  SLOT_NONE  = '0;
    localparam logic [SLOT_W-1:0]  SLOT_FIRST = SLOT_W'(1);
    localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(NUM_TASKS - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_HIGH   = 2'd3;

    // Input item kinds; the fourth code has no meaning and does nothing.
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK      = 2'd0,
        KIND_RUN       = 2'd1,
        KIND_SET_READY = 2'd2
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic tick_step;
        logic grant;
        logic set_ready;
        logic mod_step;
        logic mod_write;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              found_mod;
        logic              tick_last;
        logic              mod_last;
        logic              out_free;
    } t_stat;

endpackage

// ===== rtl/pts_ctrl.sv =====
`timescale 1ns / 1ps

module pts_ctrl
    import pts_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_TICK,
        S_MOD,
        S_MOD_WB,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.kind)
                    KIND_TICK: begin
                        n_state = S_TICK;
                    end
                    KIND_RUN: begin
                        o_cmd.grant = 1'b1;
                        n_state     = i_stat.found_mod ? S_MOD : S_RESULT;
                    end
                    KIND_SET_READY: begin
                        o_cmd.set_ready = 1'b1;
                        n_state         = S_RESULT;
                    end
                    default: begin
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_TICK: begin
                o_cmd.tick_step = 1'b1;
                if (i_stat.tick_last) begin
                    n_state = S_RESULT;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_MOD_WB;
                end
            end
            S_MOD_WB: begin
                o_cmd.mod_write = 1'b1;
                n_state         = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // An accepted transaction always moves the controller into dispatch.
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_DISPATCH))
        else $error("accepted item did not reach dispatch");

    // The result is only loaded from the result state.
    a_load_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (r_state == S_RESULT))
        else $error("result loaded outside the result state");

endmodule

// ===== rtl/pts_dp.sv =====
`timescale 1ns / 1ps

module pts_dp
    import pts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [SLOT_W-1:0]     i_task_index,
    input  logic                  i_out_ready,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic                  o_valid,
    output logic                  o_granted,
    output logic [SLOT_W-1:0]     o_granted_task,
    output logic [NUM_TASKS-1:0]  o_ready_after
);

    // Configuration.
    logic [NUM_TASKS-1:0]  r_enable;
    logic [NUM_TASKS-1:0]  r_periodic;
    logic [CFG_DATA_W-1:0] r_period_lo;
    logic [CFG_DATA_W-1:0] r_period_hi;

    // Scheduler state.
    logic [NUM_TASKS-1:0] r_ready;
    logic [COUNT_W-1:0]   r_count [NUM_TASKS];

    // Current item.
    logic [KIND_W-1:0] r_kind;
    logic [SLOT_W-1:0] r_index;
    logic [SLOT_W-1:0] r_slot;
    logic              r_granted;
    logic [SLOT_W-1:0] r_task;

    // Remainder unit, one quotient bit per cycle.
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_dvd;
    logic [COUNT_W-1:0] r_div;
    logic [STEP_W-1:0]  r_step;

    // Output register.
    logic                 r_out_valid;
    logic                 r_out_granted;
    logic [SLOT_W-1:0]    r_out_task;
    logic [NUM_TASKS-1:0] r_out_ready;

    logic [COUNT_W-1:0] w_period [NUM_TASKS];
    logic               w_found;
    logic [SLOT_W-1:0]  w_first;
    logic               w_needs_mod;
    logic [COUNT_W-1:0] w_inc;
    logic [COUNT_W:0]   w_trial;
    logic               w_fits;

    always_comb begin
        for (int i = 0; i < NUM_TASKS; i++) begin
            if (i < PERIODS_PER_WORD) begin
                w_period[i] = r_period_lo[COUNT_W*i +: COUNT_W];
            end else begin
                w_period[i] = r_period_hi[COUNT_W*(i-PERIODS_PER_WORD) +: COUNT_W];
            end
        end
    end

    // Lowest-numbered ready task; slot 0 never competes.
    always_comb begin
        w_found = 1'b0;
        w_first = SLOT_NONE;
        for (int i = NUM_TASKS - 1; i >= 1; i--) begin
            if (r_ready[i]) begin
                w_found = 1'b1;
                w_first = SLOT_W'(i);
            end
        end
    end

    assign w_needs_mod = r_periodic[w_first] && (w_period[w_first] != '0);
    assign w_inc       = (r_count[r_slot] == COUNT_MAX) ? r_count[r_slot]
                                                         : r_count[r_slot] + 1'b1;
    assign w_trial     = {r_rem, r_dvd[COUNT_W-1]};
    assign w_fits      = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= '0;
            r_periodic  <= '0;
            r_period_lo <= '0;
            r_period_hi <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENABLE_MASK:   r_enable    <= i_cfg_data[NUM_TASKS-1:0];
                CFG_PERIODIC_MASK: r_periodic  <= i_cfg_data[NUM_TASKS-1:0];
                CFG_PERIOD_LOW:    r_period_lo <= i_cfg_data;
                CFG_PERIOD_HIGH:   r_period_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= '0;
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            if (i_cmd.tick_step && r_enable[r_slot]) begin
                r_count[r_slot] <= w_inc;
                if (w_inc > w_period[r_slot]) begin
                    r_ready[r_slot] <= 1'b1;
                end
            end
            if (i_cmd.grant && w_found) begin
                r_ready[w_first] <= 1'b0;
                if (!w_needs_mod) begin
                    r_count[w_first] <= '0;
                end
            end
            if (i_cmd.set_ready && r_index != SLOT_NONE) begin
                r_ready[r_index] <= 1'b1;
            end
            if (i_cmd.mod_write) begin
                r_count[r_task] <= r_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind    <= i_kind;
            r_index   <= i_task_index;
            r_slot    <= SLOT_FIRST;
            r_granted <= 1'b0;
            r_task    <= SLOT_NONE;
        end
        if (i_cmd.tick_step) begin
            r_slot <= r_slot + 1'b1;
        end
        if (i_cmd.grant) begin
            r_granted <= w_found;
            r_task    <= w_first;
            r_rem     <= '0;
            r_dvd     <= r_count[w_first];
            r_div     <= w_period[w_first];
            r_step    <= STEP_W'(COUNT_W);
        end
        if (i_cmd.mod_step) begin
            r_rem  <= w_fits ? COUNT_W'(w_trial - {1'b0, r_div}) : w_trial[COUNT_W-1:0];
            r_dvd  <= {r_dvd[COUNT_W-2:0], 1'b0};
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_granted <= r_granted;
            r_out_task    <= r_task;
            r_out_ready   <= r_ready;
        end
    end

    assign o_stat.kind      = r_kind;
    assign o_stat.found_mod = w_found && w_needs_mod;
    assign o_stat.tick_last = (r_slot == SLOT_LAST);
    assign o_stat.mod_last  = (r_step == STEP_W'(1));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_valid        = r_out_valid;
    assign o_granted      = r_out_granted;
    assign o_granted_task = r_out_task;
    assign o_ready_after  = r_out_ready;

    // Slot 0 can never become ready.
    a_slot0_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ready[0])
        else $error("slot 0 marked ready");

    // A granted result always names a real task.
    a_grant_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_granted) |-> (r_out_task != SLOT_NONE))
        else $error("grant without task");

    // The remainder write-back belongs to a granted run.
    a_mod_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mod_write |-> (r_granted && r_step == '0))
        else $error("remainder written without grant");

endmodule

// ===== rtl/periodic_task_priority_scheduler.sv =====
`timescale 1ns / 1ps

// Eight-slot periodic task scheduler with a priority bitmap.
// Input channel (i_valid / o_ready): each transaction carries i_kind (tick, run,
// set-ready) and i_task_index. One item is handled at a time; o_ready is high
// only while the controller is idle.
// Output channel (o_valid / i_ready): one result transaction per item with the
// grant flag, the granted slot and the ready bitmap after the item.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): register
// index 0 enable mask, 1 periodic mask, 2 and 3 the packed period words.
// From acceptance to o_valid: set-ready, unused kinds and runs that need no
// remainder pass from dispatch straight to the result state; a tick walks slots
// 1 to 7 through one counter update per cycle; a run of a periodic task with a
// nonzero period goes through the 16-step shift-subtract remainder unit and a
// write-back state. The controller returns to idle as the result is loaded and
// accepts the next item in the cycle after, never before that result is loaded.
// Reset (synchronous, active low) clears all configuration, ready bits and
// elapsed counts. When the receiver stalls, the result is held in the output
// register; the next item is still accepted and runs until its own result
// waits for the output register to drain.
module periodic_task_priority_scheduler
    import pts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [SLOT_W-1:0]     i_task_index,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_granted,
    output logic [SLOT_W-1:0]     o_granted_task,
    output logic [NUM_TASKS-1:0]  o_ready_after
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    // The controller sequences each item; the datapath holds all state.
    pts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_ready (o_ready),
        .o_cmd   (w_cmd)
    );

    pts_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_task_index   (i_task_index),
        .i_out_ready    (i_ready),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_valid        (o_valid),
        .o_granted      (o_granted),
        .o_granted_task (o_granted_task),
        .o_ready_after  (o_ready_after)
    );

endmodule

// ===== test/tb_periodic_task_priority_scheduler.sv =====
`timescale 1ns / 1ps

// The testbench runs the scheduler through four directed tests aimed at single features
// (reset state, priority order and periods, disabled slots, zero periods), one long output
// stall, and three phases of random traffic with different idle patterns on the two channels.
module tb_periodic_task_priority_scheduler;
    import pts_pkg::*;

    // The input kind that has no meaning. The block must answer it without any state change.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 5;
    // The longest item is a periodic run with a nonzero period, through the remainder unit.
    // SETTLE_CYCLES is chosen to outlast it, so that the controller is idle.
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_SEND_GAP   = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    // One scheduler answer: the grant flag, the granted slot and the ready bitmap.
    typedef struct packed {
        logic                 granted;
        logic [SLOT_W-1:0]    granted_slot;
        logic [NUM_TASKS-1:0] ready_map;
    } t_sched_result;

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_valid        = 1'b0;
    logic [KIND_W-1:0]     i_kind         = '0;
    logic [SLOT_W-1:0]     i_task_index   = '0;
    logic                  i_ready        = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_ready;
    logic                  o_valid;
    logic                  o_granted;
    logic [SLOT_W-1:0]     o_granted_task;
    logic [NUM_TASKS-1:0]  o_ready_after;

    // This is the testbench's own copy of the scheduler state and of its registers.
    logic [NUM_TASKS-1:0]  model_ready;
    logic [COUNT_W-1:0]    model_count [NUM_TASKS];
    logic [NUM_TASKS-1:0]  model_enable;
    logic [NUM_TASKS-1:0]  model_periodic;
    logic [CFG_DATA_W-1:0] model_period_lo;
    logic [CFG_DATA_W-1:0] model_period_hi;

    // This queue holds the expected answers in the order that the items were accepted.
    t_sched_result pending_results [$];

    int  mismatch_count = 0;
    int  snd_idle_pct   = 0;
    int  rcv_idle_pct   = 0;
    int  quiet_cycles   = 0;
    bit  rcv_held       = 1'b0;
    event hold_off_ev;

    periodic_task_priority_scheduler u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_task_index   (i_task_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_granted      (o_granted),
        .o_granted_task (o_granted_task),
        .o_ready_after  (o_ready_after)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // The period of a slot is unpacked from the two period words, four 16-bit fields each.
    function automatic logic [COUNT_W-1:0] slot_period(input int slot);
        if (slot < PERIODS_PER_WORD)
            return model_period_lo[COUNT_W*slot +: COUNT_W];
        return model_period_hi[COUNT_W*(slot-PERIODS_PER_WORD) +: COUNT_W];
    endfunction

    // This function applies one accepted item to the scheduler state and returns the answer
    // that the block must give for it.
    function automatic t_sched_result schedule_item(input logic [KIND_W-1:0] kind,
                                                    input logic [SLOT_W-1:0] slot);
        t_sched_result      res;
        logic [COUNT_W-1:0] per;
        res = '0;
        case (kind)
            KIND_TICK: begin
                // Slot 0 is never counted. Each count stops at its all-ones value.
                for (int i = 1; i < NUM_TASKS; i++) begin
                    if (model_enable[i]) begin
                        if (model_count[i] != COUNT_MAX)
                            model_count[i] = model_count[i] + 1'b1;
                        if (model_count[i] > slot_period(i))
                            model_ready[i] = 1'b1;
                    end
                end
            end
            KIND_RUN: begin
                // The lowest-numbered ready slot wins. A run acts on disabled slots too.
                for (int i = 1; i < NUM_TASKS; i++) begin
                    if (model_ready[i] && !res.granted) begin
                        per = slot_period(i);
                        if (model_periodic[i])
                            model_count[i] = (per == '0) ? '0 : model_count[i] % per;
                        else
                            model_count[i] = '0;
                        model_ready[i]   = 1'b0;
                        res.granted      = 1'b1;
                        res.granted_slot = SLOT_W'(i);
                    end
                end
            end
            KIND_SET_READY: begin
                // Slot 0 stands for "no task", so marking it ready must not take effect.
                if (slot != SLOT_NONE)
                    model_ready[slot] = 1'b1;
            end
            default: ;
        endcase
        res.ready_map = model_ready;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // This task offers one item, waits for its input transaction and records the expected answer.
    // It drops valid only for a random gap before the item. The step in which an item is
    // accepted therefore never sees two assignments to i_valid.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot);
        int gap;
        gap = 0;
        while (gap < MAX_SEND_GAP && $urandom_range(99) < snd_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_task_index <= slot;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(schedule_item(kind, slot));
    endtask

    task automatic send_random_item();
        int                pick;
        logic [KIND_W-1:0] kind;
        pick = $urandom_range(99);
        if (pick < 45)
            kind = KIND_TICK;
        else if (pick < 75)
            kind = KIND_RUN;
        else if (pick < 95)
            kind = KIND_SET_READY;
        else
            kind = KIND_UNUSED;
        send_item(kind, SLOT_W'($urandom_range(NUM_TASKS - 1)));
    endtask

    // The sender stops and waits until every expected answer has come back. It then waits
    // out the settle time so that register writes find the block idle.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // This task writes one register. It leaves i_cfg_valid high so that writes can follow
    // back to back. The caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_ENABLE_MASK:   model_enable    = data[NUM_TASKS-1:0];
            CFG_PERIODIC_MASK: model_periodic  = data[NUM_TASKS-1:0];
            CFG_PERIOD_LOW:    model_period_lo = data;
            CFG_PERIOD_HIGH:   model_period_hi = data;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [NUM_TASKS-1:0]  enable,
                               input logic [NUM_TASKS-1:0]  periodic,
                               input logic [CFG_DATA_W-1:0] per_lo,
                               input logic [CFG_DATA_W-1:0] per_hi);
        write_reg(CFG_ENABLE_MASK, CFG_DATA_W'(enable));
        write_reg(CFG_PERIODIC_MASK, CFG_DATA_W'(periodic));
        write_reg(CFG_PERIOD_LOW, per_lo);
        write_reg(CFG_PERIOD_HIGH, per_hi);
        i_cfg_valid <= 1'b0;
    endtask

    // A random mask is weighted toward the two extremes.
    function automatic logic [NUM_TASKS-1:0] random_mask();
        case ($urandom_range(7))
            0:       return '1;
            1:       return '0;
            default: return NUM_TASKS'($urandom);
        endcase
    endfunction

    // The largest share of periods is short so that ticks make slots ready often. A few periods are long,
    // zero, all ones or fully random, so that every bit of a period word is exercised.
    function automatic logic [CFG_DATA_W-1:0] random_period_word();
        logic [CFG_DATA_W-1:0] word;
        for (int f = 0; f < PERIODS_PER_WORD; f++) begin
            case ($urandom_range(9))
                0, 1:       word[COUNT_W*f +: COUNT_W] = '0;
                2, 3, 4, 5: word[COUNT_W*f +: COUNT_W] = COUNT_W'($urandom_range(6, 1));
                6, 7:       word[COUNT_W*f +: COUNT_W] = COUNT_W'($urandom_range(40, 7));
                8:          word[COUNT_W*f +: COUNT_W] = COUNT_MAX;
                default:    word[COUNT_W*f +: COUNT_W] = COUNT_W'($urandom);
            endcase
        end
        return word;
    endfunction

    // ------------------------------------------------------------------
    // Receiver, result checker and watchdog
    // ------------------------------------------------------------------

    // The receiver stalls at random at the current idle rate. During a hold-off it is held
    // low without a break.
    always @(posedge i_clk) begin
        if (rcv_held)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // This process owns the long hold-off and counts its length in cycles.
    always begin
        @(hold_off_ev);
        rcv_held = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rcv_held = 1'b0;
    end

    always @(posedge i_clk) begin : result_check
        t_sched_result want;
        if (o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result transaction with no item waiting (granted %0b task %0d ready %b)",
                         $time, o_granted, o_granted_task, o_ready_after);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_granted !== want.granted) begin
                    $display("%0t: granted expected %0b, got %0b",
                             $time, want.granted, o_granted);
                    mismatch_count++;
                end
                if (o_granted_task !== want.granted_slot) begin
                    $display("%0t: granted_task expected %0d, got %0d",
                             $time, want.granted_slot, o_granted_task);
                    mismatch_count++;
                end
                if (o_ready_after !== want.ready_map) begin
                    $display("%0t: ready_after expected %b, got %b",
                             $time, want.ready_map, o_ready_after);
                    mismatch_count++;
                end
            end
        end
    end

    // A stuck handshake shows up as a long stretch in which no transaction completes on any
    // of the three channels.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, no transaction for %0d cycles", $time, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset no slot is enabled and none is ready. Ticks therefore do nothing, and a run
    // finds no task. The unused kind must also leave the state alone.
    task automatic test_idle_after_reset();
        send_item(KIND_RUN, SLOT_LAST);
        send_item(KIND_TICK, SLOT_NONE);
        send_item(KIND_UNUSED, SLOT_LAST);
        drain_results();
    endtask

    // This test mixes periods across the slots: zero, short, one, and all ones (which is never
    // exceeded here). Slots 1, 2, 4 and 6 are periodic. Slot 1 is periodic with a zero period.
    // The runs must come out in slot order. A set-ready of slot 0 must be ignored.
    task automatic test_priority_and_periods();
        load_config(8'hFF, 8'h56,
                    {16'd0, 16'd2, 16'd0, 16'd3},
                    {16'd0, 16'd4, COUNT_MAX, 16'd1});
        send_item(KIND_RUN, SLOT_NONE);
        send_item(KIND_SET_READY, SLOT_NONE);
        send_item(KIND_UNUSED, SLOT_NONE);
        repeat (3) send_item(KIND_TICK, SLOT_LAST);
        repeat (6) send_item(KIND_RUN, SLOT_NONE);
        send_item(KIND_SET_READY, SLOT_LAST);
        send_item(KIND_SET_READY, 3'd5);
        repeat (2) send_item(KIND_RUN, SLOT_FIRST);
        repeat (6) send_item(KIND_TICK, SLOT_NONE);
        repeat (4) send_item(KIND_RUN, SLOT_NONE);
        drain_results();
    endtask

    // When every slot is disabled, ticks change nothing. A set-ready and a run still act on a
    // disabled slot. Its period of all ones makes its count stay as it is when it runs.
    task automatic test_disabled_tasks();
        load_config(8'h00, 8'hFF, '1, '1);
        send_item(KIND_SET_READY, 3'd4);
        send_item(KIND_TICK, SLOT_NONE);
        send_item(KIND_RUN, SLOT_NONE);
        send_item(KIND_RUN, SLOT_NONE);
        drain_results();
    endtask

    // With all periods at zero, one tick makes every enabled slot but slot 0 ready. Periodic slots then
    // run with a zero period, and their counts must come back as zero.
    task automatic test_zero_periods();
        load_config(8'hFF, 8'hFF, '0, '0);
        send_item(KIND_TICK, SLOT_NONE);
        repeat (3) send_item(KIND_RUN, SLOT_NONE);
        send_item(KIND_TICK, SLOT_NONE);
        drain_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering items. The
    // output register and the item in flight fill up, and the input must stall until the
    // receiver lets go.
    task automatic test_output_backpressure();
        load_config(8'hFE, random_mask(), random_period_word(), random_period_word());
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        -> hold_off_ev;
        repeat (40) send_random_item();
        drain_results();
    endtask

    // Random traffic runs under four register setups per phase. Every setup starts with the
    // sender paused until all answers are in.
    task automatic test_random_traffic(input int items, input int snd_pct, input int rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (int setup = 0; setup < 4; setup++) begin
            drain_results();
            load_config(random_mask(), random_mask(), random_period_word(), random_period_word());
            repeat (items / 4) send_random_item();
        end
        drain_results();
    endtask

    initial begin
        model_ready     = '0;
        model_enable    = '0;
        model_periodic  = '0;
        model_period_lo = '0;
        model_period_hi = '0;
        for (int i = 0; i < NUM_TASKS; i++)
            model_count[i] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle_pct = 36;
        rcv_idle_pct = 78;
        test_idle_after_reset();
        test_priority_and_periods();
        test_disabled_tasks();
        test_zero_periods();
        test_output_backpressure();

        test_random_traffic(560, 36, 78);
        test_random_traffic(560, 78, 36);
        test_random_traffic(560, 0, 0);

        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pts_pkg.sv
rtl/pts_ctrl.sv
rtl/pts_dp.sv
rtl/periodic_task_priority_scheduler.sv
test/tb_periodic_task_priority_scheduler.sv
